// ===== sv/lir_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
// Used by lir_lane, lir_merge and linear_interp_resampler; depends on nothing.
`default_nettype none
package lir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int PHASE_W    = 19;
    localparam int CHAN_W     = 2;
    localparam int MAX_RUN    = 7;
    localparam int RUN_CNT_W  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [PHASE_W-1:0] STEP_RESET = 19'd65536;
    localparam logic [CHAN_W-1:0]  CHAN_RESET = 2'd2;
    localparam logic [CHAN_W-1:0]  CHAN_STEREO = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_PHASE_STEP    = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic valid;
        logic last;
    } push_ctl_t;

    typedef struct packed {
        logic    last;
        sample_t right;
        sample_t left;
    } out_word_t;

endpackage
`default_nettype wire

// ===== sv/lir_lane.sv =====
// One channel of the interpolator: prev + floor((cur - prev) * frac / 2^FRAC_BITS).
// Two register stages (product, sum); uses lir_pkg for the sample type.
`default_nettype none
module lir_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire lir_pkg::sample_t       a_in,
    input  wire lir_pkg::sample_t       b_in,
    input  wire logic [FRAC_BITS-1:0]   frac_in,
    output lir_pkg::sample_t            y_out
);
    localparam int DIFF_W = lir_pkg::SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
    localparam int SUM_W  = lir_pkg::SAMPLE_W + 2;

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    lir_pkg::sample_t         a_reg;
    logic signed [SUM_W-1:0]  shifted;
    logic signed [SUM_W-1:0]  sum;
    lir_pkg::sample_t         y_reg;

    assign diff      = DIFF_W'(b_in) - DIFF_W'(a_in);
    assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, frac_in}));

    // signed shift floors toward minus infinity
    assign shifted = $signed(prod_reg[PROD_W-1:FRAC_BITS]);
    assign sum     = SUM_W'(a_reg) + shifted;

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        a_reg    <= a_in;
        y_reg    <= sum[lir_pkg::SAMPLE_W-1:0];
    end

    assign y_out = y_reg;

endmodule
`default_nettype wire

// ===== sv/lir_merge.sv =====
// Merge stage: joins the two lane results into one output word and queues it.
// Small register FIFO in front of the master channel; uses lir_pkg.
`default_nettype none
module lir_merge (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire lir_pkg::push_ctl_t                  push_in,
    input  wire lir_pkg::sample_t                    left_in,
    input  wire lir_pkg::sample_t                    right_in,
    input  wire logic                                stereo_in,
    output logic [lir_pkg::FIFO_CNT_W-1:0]           count_out,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [31:0]                              m_tdata,   // left_out, right_out
    output logic                                     m_tlast    // last_of_run
);
    lir_pkg::out_word_t                     mem_reg [lir_pkg::FIFO_DEPTH];
    lir_pkg::out_word_t                     word_in;
    lir_pkg::out_word_t                     head;
    logic [lir_pkg::FIFO_PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [lir_pkg::FIFO_PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [lir_pkg::FIFO_CNT_W-1:0]         count_reg, count_next;
    logic                                   pop;

    always_comb begin
        word_in.left  = left_in;
        // mono forces the right channel to zero
        word_in.right = stereo_in ? right_in : '0;
        word_in.last  = push_in.last;
    end

    assign head = mem_reg[rd_ptr_reg];
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = push_in.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push_in.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push_in.valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_in.valid) begin
            mem_reg[wr_ptr_reg] <= word_in;
        end
    end

    assign count_out = count_reg;
    assign m_tvalid  = (count_reg != '0);
    assign m_tdata   = {head.right, head.left};
    assign m_tlast   = head.last;

endmodule
`default_nettype wire

// ===== sv/linear_interp_resampler.sv =====
// Linear interpolation sample rate converter.
// Input words on s_*: one mono or stereo frame (tdata) and a block-start flag (tuser).
// Output words on m_*: interpolated frames, tlast on the final one an input causes.
// An input is taken only while the sequencer is idle. A frame that produces
// results is accepted, then issued to the lanes one result per issue, each
// issue waiting for queue room; a frame that produces none never leaves idle.
// At most seven results per frame; the issue loop over output positions sets this.
// From accept, the first result passes the run state, the lane product register,
// the lane sum register and the output queue before it shows on m_tvalid.
// Two lanes (left, right) interpolate in parallel; a merge stage packs the result
// into a four-word queue. The sequencer issues only while the queue has room, so
// a stalled receiver just holds issue; nothing is dropped.
// Registers (APB): 0x0 phase_step (3.16 step, 65536 = bypass), 0x4 channel_count
// (2 stereo, otherwise mono). Write them only while idle.
// Reset (aresetn low, synchronous) empties the queue, clears the stored frame and
// phase, and restores phase_step = 65536, channel_count = 2.
`default_nettype none
module linear_interp_resampler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // left_sample, right_sample
    input  wire logic [0:0]  s_tuser,   // block_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // left_out, right_out
    output logic             m_tlast,   // last_of_run
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int FRAC_BITS = lir_pkg::FRAC_BITS;
    localparam int PHASE_W = lir_pkg::PHASE_W;
    localparam int ACC_W   = ((FRAC_BITS + 1 > PHASE_W) ? FRAC_BITS + 1 : PHASE_W) + 1;
    localparam logic [ACC_W-1:0] ONE = {{(ACC_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                              state_reg;
    logic [PHASE_W-1:0]                  step_reg;
    logic [lir_pkg::CHAN_W-1:0]          chan_reg;
    lir_pkg::sample_t                    prev_left_reg, prev_right_reg;
    lir_pkg::sample_t                    cur_left_reg, cur_right_reg;
    logic                                have_prev_reg;
    logic [PHASE_W-1:0]                  phase_reg;
    logic [ACC_W-1:0]                    acc_reg;
    logic [lir_pkg::RUN_CNT_W-1:0]       run_cnt_reg;
    logic                                v1_reg, v2_reg, last1_reg, last2_reg;

    logic                                stereo;
    lir_pkg::sample_t                    in_left, in_right;
    logic                                in_start, s_accept, cfg_write, bypass;
    logic [ACC_W-1:0]                    phase_ext, step_ext, acc_sum;
    logic [ACC_W-1:0]                    acc_wrap, phase_wrap;
    logic [PHASE_W-1:0]                  next_phase;
    logic [lir_pkg::FIFO_CNT_W-1:0]      fifo_count, pending;
    logic                                credit_ok, issue, issue_last;
    lir_pkg::sample_t                    lane_left, lane_right;
    lir_pkg::push_ctl_t                  push_ctl;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            lir_pkg::REG_PHASE_STEP:    prdata = 32'(step_reg);
            lir_pkg::REG_CHANNEL_COUNT: prdata = 32'(chan_reg);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign stereo   = (chan_reg == lir_pkg::CHAN_STEREO);
    assign in_left  = s_tdata[15:0];
    assign in_right = stereo ? s_tdata[31:16] : '0;
    assign in_start = s_tuser[0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign phase_ext  = ACC_W'(phase_reg);
    assign step_ext   = ACC_W'(step_reg);
    assign bypass     = (step_ext == ONE);
    assign acc_sum    = acc_reg + step_ext;
    assign acc_wrap   = acc_sum - ONE;
    assign phase_wrap = phase_ext - ONE;
    assign next_phase = (acc_sum >= ONE) ? acc_wrap[PHASE_W-1:0] : '0;

    // queue entries plus words still in the lanes must leave room for one more
    assign pending    = fifo_count + lir_pkg::FIFO_CNT_W'(v1_reg)
                      + lir_pkg::FIFO_CNT_W'(v2_reg);
    assign credit_ok  = (pending < lir_pkg::FIFO_CNT_W'(lir_pkg::FIFO_DEPTH));
    assign issue      = (state_reg == ST_RUN) && credit_ok;
    assign issue_last = (acc_sum >= ONE)
                     || (run_cnt_reg == lir_pkg::RUN_CNT_W'(lir_pkg::MAX_RUN - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= lir_pkg::STEP_RESET;
            chan_reg       <= lir_pkg::CHAN_RESET;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            have_prev_reg  <= 1'b0;
            phase_reg      <= '0;
            run_cnt_reg    <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[2])
                    lir_pkg::REG_PHASE_STEP:    step_reg <= pwdata[PHASE_W-1:0];
                    lir_pkg::REG_CHANNEL_COUNT: chan_reg <= pwdata[lir_pkg::CHAN_W-1:0];
                    default:                    step_reg <= step_reg;
                endcase
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        priority if (bypass) begin
                            // interpolate cur against itself at zero phase
                            prev_left_reg  <= in_left;
                            prev_right_reg <= in_right;
                            have_prev_reg  <= 1'b1;
                            acc_reg        <= '0;
                            run_cnt_reg    <= '0;
                            state_reg      <= ST_RUN;
                        end else if (in_start || !have_prev_reg) begin
                            prev_left_reg  <= in_left;
                            prev_right_reg <= in_right;
                            have_prev_reg  <= 1'b1;
                            phase_reg      <= '0;
                        end else if (phase_ext >= ONE) begin
                            // no position in this interval: skip ahead
                            prev_left_reg  <= in_left;
                            prev_right_reg <= in_right;
                            phase_reg      <= phase_wrap[PHASE_W-1:0];
                        end else begin
                            acc_reg        <= phase_ext;
                            run_cnt_reg    <= '0;
                            state_reg      <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        acc_reg     <= acc_sum;
                        run_cnt_reg <= run_cnt_reg + 1'b1;
                        if (issue_last) begin
                            phase_reg      <= next_phase;
                            prev_left_reg  <= cur_left_reg;
                            prev_right_reg <= cur_right_reg;
                            state_reg      <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cur_left_reg  <= in_left;
            cur_right_reg <= in_right;
        end
        last1_reg <= issue_last;
        last2_reg <= last1_reg;
    end

    // ---------------- lanes ----------------
    lir_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_left (
        .aclk    (aclk),
        .a_in    (prev_left_reg),
        .b_in    (cur_left_reg),
        .frac_in (acc_reg[FRAC_BITS-1:0]),
        .y_out   (lane_left)
    );

    lir_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_right (
        .aclk    (aclk),
        .a_in    (prev_right_reg),
        .b_in    (cur_right_reg),
        .frac_in (acc_reg[FRAC_BITS-1:0]),
        .y_out   (lane_right)
    );

    // ---------------- merge ----------------
    always_comb begin
        push_ctl.valid = v2_reg;
        push_ctl.last  = last2_reg;
    end

    lir_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_in   (push_ctl),
        .left_in   (lane_left),
        .right_in  (lane_right),
        .stereo_in (stereo),
        .count_out (fifo_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ---------------- checks ----------------
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        pending <= lir_pkg::FIFO_CNT_W'(lir_pkg::FIFO_DEPTH))
        else $error("output queue plus lanes exceed queue depth");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && issue_last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after its last word");

    a_run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (run_cnt_reg < lir_pkg::RUN_CNT_W'(lir_pkg::MAX_RUN)))
        else $error("more than seven words issued for one frame");

    a_push_after_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |=> ##1 push_ctl.valid)
        else $error("issued word did not reach the merge stage");

endmodule
`default_nettype wire

// ===== dv/linear_interp_resampler_tb.sv =====
// Self-checking testbench for linear_interp_resampler: random and directed frames,
// APB register settings across the full field ranges, random stalls on both streams.
// Depends on lir_pkg (sample and output word types, register indexes).
module linear_interp_resampler_tb;

    localparam int FRAC_BITS = lir_pkg::FRAC_BITS;
    localparam int unsigned UNIT_PHASE = 32'd1 << FRAC_BITS;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LEN = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        bit               start;
        lir_pkg::sample_t left;
        lir_pkg::sample_t right;
    } frame_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // left_sample, right_sample
    logic [0:0]  s_tuser = '0;   // block_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // left_out, right_out
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    linear_interp_resampler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // interpolator shadow state
    logic [lir_pkg::PHASE_W-1:0] step_reg = lir_pkg::STEP_RESET;
    logic [lir_pkg::CHAN_W-1:0]  chan_reg = lir_pkg::CHAN_RESET;
    lir_pkg::sample_t            held_left = '0;
    lir_pkg::sample_t            held_right = '0;
    bit                          held_valid = 1'b0;
    int unsigned                 phase_pos = 0;

    frame_t             pending_frames[$];
    lir_pkg::out_word_t expected_outs[$];

    int  frames_queued = 0;
    int  frames_taken = 0;
    int  outs_seen = 0;
    int  fail_count = 0;
    int  settings_run = 0;
    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  stall_kick = 1'b0;
    bit  stall_seen = 1'b0;
    bit  s_fire = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic lir_pkg::sample_t interp_point(lir_pkg::sample_t a,
                                                      lir_pkg::sample_t b,
                                                      int unsigned frac);
        longint span;
        longint prod;
        span = longint'(b) - longint'(a);
        prod = span * longint'(frac);
        // arithmetic shift floors, matching the rounding toward minus infinity
        return lir_pkg::sample_t'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    task automatic predict_outputs(bit start, lir_pkg::sample_t l_in, lir_pkg::sample_t r_in);
        lir_pkg::out_word_t w;
        lir_pkg::sample_t   cur_right;
        bit                 stereo;
        int                 n;
        stereo = (chan_reg == lir_pkg::CHAN_STEREO);
        cur_right = stereo ? r_in : lir_pkg::sample_t'(0);
        n = 0;
        if (int'(step_reg) == UNIT_PHASE) begin
            w.left = l_in;
            w.right = cur_right;
            w.last = 1'b1;
            expected_outs.push_back(w);
            phase_pos = 0;
        end else if (start || !held_valid) begin
            phase_pos = 0;
        end else begin
            while (n < lir_pkg::MAX_RUN && phase_pos < UNIT_PHASE) begin
                w.left = interp_point(held_left, l_in, phase_pos);
                w.right = stereo ? interp_point(held_right, cur_right, phase_pos)
                                 : lir_pkg::sample_t'(0);
                w.last = (n + 1 == lir_pkg::MAX_RUN) || (phase_pos + step_reg >= UNIT_PHASE);
                expected_outs.push_back(w);
                n++;
                phase_pos += step_reg;
            end
            // drop positions left over after a full run
            phase_pos = (phase_pos >= UNIT_PHASE) ? phase_pos - UNIT_PHASE : 0;
        end
        held_left = l_in;
        held_right = cur_right;
        held_valid = 1'b1;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at output word %0d: %s got %0d, want %0d", outs_seen, what, got, want);
        fail_count++;
    endtask

    // sample both streams; check first, since a frame taken now cannot emit this edge
    always @(posedge aclk) begin : monitor
        lir_pkg::out_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_outs.size() == 0) begin
                report_mismatch("word with nothing pending, left_out",
                                int'(lir_pkg::sample_t'(m_tdata[15:0])), 0);
            end else begin
                want = expected_outs.pop_front();
                if (m_tdata[15:0] !== want.left)
                    report_mismatch("left_out", int'(lir_pkg::sample_t'(m_tdata[15:0])),
                                    int'(want.left));
                if (m_tdata[31:16] !== want.right)
                    report_mismatch("right_out", int'(lir_pkg::sample_t'(m_tdata[31:16])),
                                    int'(want.right));
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", int'(m_tlast), int'(want.last));
            end
            outs_seen++;
        end
        if (aresetn && s_tvalid && s_tready) begin
            predict_outputs(s_tuser[0], lir_pkg::sample_t'(s_tdata[15:0]),
                            lir_pkg::sample_t'(s_tdata[31:16]));
            frames_taken++;
        end
        s_fire <= aresetn && s_tvalid && s_tready;
    end

    always @(posedge aclk) begin
        if ((aresetn && s_tvalid && s_tready) || (aresetn && m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // source: advance only once the current word is taken
    always @(negedge aclk) begin : source
        frame_t f;
        if (!s_tvalid || s_fire) begin
            if (pending_frames.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                f = pending_frames.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {f.right, f.left};
                s_tuser <= f.start;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sink: long hold-off on request, otherwise random backpressure
    always @(negedge aclk) begin
        if (stall_kick != stall_seen) begin
            stall_seen <= stall_kick;
            stall_left <= STALL_LEN;
            m_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == lir_pkg::REG_PHASE_STEP)
            step_reg = val[lir_pkg::PHASE_W-1:0];
        else
            chan_reg = val[lir_pkg::CHAN_W-1:0];
    endtask

    task automatic queue_frame(bit start, lir_pkg::sample_t l, lir_pkg::sample_t r);
        frame_t f;
        f.start = start;
        f.left = l;
        f.right = r;
        pending_frames.push_back(f);
        frames_queued++;
    endtask

    // hold until every frame is taken and every output has arrived, then let the
    // sequencer finish frames that produce nothing
    task automatic wait_idle();
        do @(negedge aclk); while (frames_taken != frames_queued || expected_outs.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_mode(int unsigned step, int unsigned chans);
        write_reg(lir_pkg::REG_PHASE_STEP, step);
        write_reg(lir_pkg::REG_CHANNEL_COUNT, chans);
        settings_run++;
    endtask

    // mostly well-formed blocks with random, extreme or smooth content;
    // a few stray block starts break runs midway
    task automatic queue_random(int count);
        int               run_left;
        bit               st;
        lir_pkg::sample_t l;
        lir_pkg::sample_t r;
        run_left = 0;
        l = '0;
        r = '0;
        for (int i = 0; i < count; i++) begin
            st = 1'b0;
            if (run_left == 0) begin
                st = 1'b1;
                run_left = $urandom_range(40, 4);
            end else if ($urandom_range(99) < 3) begin
                st = 1'b1;
            end
            run_left--;
            case ($urandom_range(9))
                0: begin
                    l = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                    r = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                end
                1, 2: begin
                    l = lir_pkg::sample_t'($urandom);
                    r = lir_pkg::sample_t'($urandom);
                end
                default: begin
                    l = lir_pkg::sample_t'(int'(l) + int'($urandom_range(2048)) - 1024);
                    r = lir_pkg::sample_t'(int'(r) + int'($urandom_range(2048)) - 1024);
                end
            endcase
            queue_frame(st, l, r);
        end
    endtask

    task automatic run_random(int unsigned step, int unsigned chans, int count);
        set_mode(step, chans);
        queue_random(count);
        wait_idle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset values: bypass, stereo, full-scale swings
        queue_frame(1'b1, 16'sh0000, 16'sh0000);
        queue_frame(1'b0, 16'sh7FFF, 16'sh8000);
        queue_frame(1'b0, 16'sh8000, 16'sh7FFF);
        queue_frame(1'b1, -16'sd1, 16'sd1);
        wait_idle();
        settings_run++;

        // deepest upsampling: seven points across extreme rising and falling spans
        set_mode(32'd10922, 32'd2);
        queue_frame(1'b1, 16'sh8000, 16'sh8000);
        queue_frame(1'b0, 16'sh7FFF, 16'sh7FFF);
        queue_frame(1'b0, 16'sh8000, 16'sh8000);
        queue_frame(1'b0, 16'sh8000, 16'sh7FFF);
        wait_idle();

        // zero step: run truncated at seven, phase restarts
        set_mode(32'd0, 32'd2);
        queue_frame(1'b0, 16'sd100, -16'sd100);
        queue_frame(1'b0, -16'sd5, 16'sd7);
        wait_idle();

        // largest step, mono: most frames produce nothing
        set_mode(32'h7FFFF, 32'd1);
        queue_frame(1'b1, 16'sd1000, 16'sd2000);
        queue_frame(1'b0, -16'sd1000, 16'sd555);
        queue_frame(1'b0, 16'sd3, 16'sd4);
        queue_frame(1'b0, 16'sd5, 16'sd6);
        queue_frame(1'b0, 16'sd7, 16'sd8);
        wait_idle();

        // just off bypass on either side, odd channel counts
        set_mode(32'd65535, 32'd0);
        queue_frame(1'b0, 16'sh7FFF, 16'sh7FFF);
        queue_frame(1'b0, 16'sh8000, 16'sh1234);
        queue_frame(1'b0, 16'sh7FFF, -16'sd1);
        wait_idle();
        set_mode(32'd65537, 32'd3);
        queue_frame(1'b0, 16'sh8000, 16'sh7FFF);
        queue_frame(1'b0, 16'sh7FFF, 16'sh8000);
        queue_frame(1'b0, 16'sh0001, 16'sh0000);
        wait_idle();

        src_idle_pct = 32;
        snk_idle_pct = 54;
        run_random(32'd60211, 32'd2, 50);
        run_random(32'd10922, 32'd1, 40);
        run_random(32'd262144, 32'd2, 120);

        src_idle_pct = 54;
        snk_idle_pct = 32;
        run_random($urandom_range(262144, 10922), 32'd2, 50);
        run_random(32'd65536, 32'd3, 30);
        run_random(32'd0, 32'd0, 20);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_mode(32'd71332, 32'd2);
        @(posedge aclk);
        stall_kick = ~stall_kick;
        queue_random(40);
        wait_idle();
        run_random(32'h7FFFF, 32'd2, 30);

        if (expected_outs.size() != 0)
            report_mismatch("outputs never delivered", 0, expected_outs.size());
        $display("Ran %0d frames through %0d register settings, %0d output words checked.",
                 frames_taken, settings_run, outs_seen);
        $display("Steps covered zero, full upsampling, bypass, downsampling and the field maximum.");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== linear_interp_resampler.f =====
sv/lir_pkg.sv
sv/lir_lane.sv
sv/lir_merge.sv
sv/linear_interp_resampler.sv
dv/linear_interp_resampler_tb.sv
